/* rtl/core/bats_pkg.sv */
// Shared types, constants and helpers for the bitmask autotile stencil core.
// No dependencies; every module of the core imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bats_pkg;

	// Geometry of the line store and cell words
	localparam int MAX_WIDTH = 256;
	localparam int CELL_BITS = 16;
	localparam int CNT_W     = $clog2(MAX_WIDTH);
	localparam int WID_W     = CNT_W + 1;
	localparam int ENT_W     = CELL_BITS + 1;   // {padding flag, cell value}

	// Fixed field widths
	localparam int ROW_W   = 10;
	localparam int COL_W   = 8;
	localparam int GW_W    = 9;
	localparam int MATCH_W = 16;
	localparam int TILE_W  = 16;
	localparam int VAL_W   = 16;
	localparam int PADDR_W = 6;
	localparam int PDATA_W = 64;

	localparam logic [ROW_W-1:0] ROW_MAX = 10'd1023;

	// Neighbor mask bit positions
	localparam int MASK_TOP   = 0;
	localparam int MASK_RIGHT = 1;
	localparam int MASK_BOT   = 2;
	localparam int MASK_LEFT  = 3;

	// Register map, one 64-bit register every 8 bytes
	typedef enum logic [2:0] {
		REG_GRID_WIDTH  = 3'd0,
		REG_MATCH_VALUE = 3'd1,
		REG_TILES_0_3   = 3'd2,
		REG_TILES_4_7   = 3'd3,
		REG_TILES_8_11  = 3'd4,
		REG_TILES_12_15 = 3'd5
	} reg_idx_t;

	typedef logic [3:0][PDATA_W-1:0] tile_bank_t;

	// Position and neighbor qualifiers of one cell being answered
	typedef struct packed {
		logic             has_result;
		logic [CNT_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             bank;       // half of the line store the new row goes to
		logic             top_ok;
		logic             right_ok;
		logic             left_ok;
		logic             bot_set;
	} slot_t;

	// Line store write request
	typedef struct packed {
		logic             en;
		logic [CNT_W-1:0] addr;
		logic             bank;
		logic [ENT_W-1:0] data;
	} mem_wr_t;

	// Line store read addresses
	typedef struct packed {
		logic [CNT_W-1:0] addr_a;   // current column: top and center
		logic [CNT_W-1:0] addr_b;   // next column: right neighbor
	} mem_rd_t;

	// Clamp the configured width into 1..MAX_WIDTH
	function automatic logic [WID_W-1:0] eff_width(input logic [GW_W-1:0] gw);
		logic [WID_W-1:0] w;
		if (gw == '0)
			w = WID_W'(1);
		else if (int'(gw) > MAX_WIDTH)
			w = WID_W'(MAX_WIDTH);
		else
			w = WID_W'(gw);
		return w;
	endfunction

	// Row count after a row change: first row stays at zero, then saturating
	function automatic logic [ROW_W-1:0] next_row_count(input logic first,
		input logic [ROW_W-1:0] row);
		logic [ROW_W-1:0] r;
		if (first || row == ROW_MAX)
			r = row;
		else
			r = row + ROW_W'(1);
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/bats_regs.sv */
// APB configuration registers: grid width, match value and the 16 tile words.
// Depends on bats_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bats_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bats_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [bats_pkg::PDATA_W-1:0]  pwdata,
	output logic      [bats_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	output logic      [bats_pkg::GW_W-1:0]     grid_width,
	output logic      [bats_pkg::MATCH_W-1:0]  match_value,
	output bats_pkg::tile_bank_t               tiles
);
	import bats_pkg::*;

	logic [GW_W-1:0]    grid_width_q;
	logic [MATCH_W-1:0] match_value_q;
	tile_bank_t         tiles_q;
	reg_idx_t           idx;
	logic               wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GW_W'(1);
			match_value_q <= MATCH_W'(1);
			tiles_q       <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[GW_W-1:0];
				REG_MATCH_VALUE: match_value_q <= pwdata[MATCH_W-1:0];
				REG_TILES_0_3:   tiles_q[0]    <= pwdata;
				REG_TILES_4_7:   tiles_q[1]    <= pwdata;
				REG_TILES_8_11:  tiles_q[2]    <= pwdata;
				REG_TILES_12_15: tiles_q[3]    <= pwdata;
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_q);
			REG_MATCH_VALUE: prdata = PDATA_W'(match_value_q);
			REG_TILES_0_3:   prdata = tiles_q[0];
			REG_TILES_4_7:   prdata = tiles_q[1];
			REG_TILES_8_11:  prdata = tiles_q[2];
			REG_TILES_12_15: prdata = tiles_q[3];
			default:         prdata = '0;
		endcase
	end

	assign grid_width  = grid_width_q;
	assign match_value = match_value_q;
	assign tiles       = tiles_q;

endmodule

`default_nettype wire

/* rtl/core/bats_line_mem.sv */
// Two-row line store: MAX_WIDTH rows, each holding one entry per row bank.
// Two registered read ports, one write port, clearing pass after reset. Depends on bats_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bats_line_mem (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            ren,
	input  bats_pkg::mem_rd_t                    rd,
	input  bats_pkg::mem_wr_t                    wr,
	output logic      [2*bats_pkg::ENT_W-1:0]    rdata_a,
	output logic      [2*bats_pkg::ENT_W-1:0]    rdata_b,
	output logic                                 busy
);
	import bats_pkg::*;

	logic [2*ENT_W-1:0] mem [MAX_WIDTH];
	logic [2*ENT_W-1:0] rdata_a_q;
	logic [2*ENT_W-1:0] rdata_b_q;
	logic               clr_busy_q;
	logic [CNT_W-1:0]   clr_addr_q;

	// Clearing sweep, one row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + CNT_W'(1);
			if (clr_addr_q == CNT_W'(MAX_WIDTH - 1))
				clr_busy_q <= 1'b0;
		end
	end

	// Storage: reads see the contents before this edge's write
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr.en) begin
			if (wr.bank)
				mem[wr.addr][2*ENT_W-1:ENT_W] <= wr.data;
			else
				mem[wr.addr][ENT_W-1:0] <= wr.data;
		end
		if (ren) begin
			rdata_a_q <= mem[rd.addr_a];
			rdata_b_q <= mem[rd.addr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;
	assign busy    = clr_busy_q;

endmodule

`default_nettype wire

/* rtl/core/bats_raster.sv */
// Raster position tracker: column, row, bank and first-row state, plus line store
// addresses and neighbor qualifiers for the incoming cell. Depends on bats_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bats_raster (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire logic [bats_pkg::VAL_W-1:0]    cell_value,
	input  wire logic                          grid_start,
	input  wire logic                          padding,
	input  wire logic [bats_pkg::GW_W-1:0]     grid_width,
	output bats_pkg::slot_t                    slot,
	output bats_pkg::mem_wr_t                  wr,
	output bats_pkg::mem_rd_t                  rd
);
	import bats_pkg::*;

	logic [CNT_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic                 bank_q;
	logic                 first_q;

	logic [WID_W-1:0]     w;
	logic [CELL_BITS-1:0] val;
	logic [CNT_W-1:0]     col_p;
	logic [ROW_W-1:0]     row_p;
	logic                 bank_p;
	logic                 first_p;
	logic [WID_W-1:0]     col_inc;
	logic [CNT_W-1:0]     col_n;
	logic [ROW_W-1:0]     row_n;
	logic                 bank_n;
	logic                 first_n;

	assign w   = eff_width(grid_width);
	assign val = padding ? '0 : CELL_BITS'(cell_value);

	// Position of this cell: grid start, or a row wrap when the width shrank
	always_comb begin
		priority if (grid_start) begin
			first_p = 1'b1;
			row_p   = '0;
			bank_p  = 1'b0;
			col_p   = '0;
		end else if (WID_W'(col_q) >= w) begin
			first_p = 1'b0;
			row_p   = next_row_count(first_q, row_q);
			bank_p  = ~bank_q;
			col_p   = '0;
		end else begin
			first_p = first_q;
			row_p   = row_q;
			bank_p  = bank_q;
			col_p   = col_q;
		end
	end

	// Position after this cell
	assign col_inc = WID_W'(col_p) + WID_W'(1);

	always_comb begin
		if (col_inc >= w) begin
			first_n = 1'b0;
			row_n   = next_row_count(first_p, row_p);
			bank_n  = ~bank_p;
			col_n   = '0;
		end else begin
			first_n = first_p;
			row_n   = row_p;
			bank_n  = bank_p;
			col_n   = col_inc[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			bank_q  <= 1'b0;
			first_q <= 1'b1;
		end else if (fire) begin
			col_q   <= col_n;
			row_q   <= row_n;
			bank_q  <= bank_n;
			first_q <= first_n;
		end
	end

	// Slot info for the answered cell
	always_comb begin
		slot.has_result = !first_p;
		slot.col        = col_p;
		slot.row        = row_p;
		slot.bank       = bank_p;
		slot.top_ok     = row_p != '0;
		slot.right_ok   = col_inc < w;
		slot.left_ok    = col_p != '0;
		slot.bot_set    = val != '0;
	end

	// New cell goes into the current bank; reads cover this and the next column
	assign wr.en     = fire;
	assign wr.addr   = col_p;
	assign wr.bank   = bank_p;
	assign wr.data   = {padding, val};
	assign rd.addr_a = col_p;
	assign rd.addr_b = col_inc[CNT_W-1:0];

	// A new grid with width above one always moves on to column one
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && grid_start && (w > WID_W'(1)) |=> col_q == CNT_W'(1))
	else $error("column did not advance after grid start");

	// Row count holds once saturated
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && !grid_start && row_q == ROW_MAX |=> row_q == ROW_MAX)
	else $error("row count left saturation");

endmodule

`default_nettype wire

/* rtl/core/bats_tile_stage.sv */
// Stencil evaluation: slot register beside the line store read data, mask and tile
// lookup, and the result register. Depends on bats_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bats_tile_stage (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  bats_pkg::slot_t                    slot_in,
	input  wire logic [2*bats_pkg::ENT_W-1:0]  rdata_a,
	input  wire logic [2*bats_pkg::ENT_W-1:0]  rdata_b,
	input  wire logic [bats_pkg::MATCH_W-1:0]  match_value,
	input  bats_pkg::tile_bank_t               tiles,
	input  wire logic                          out_stall,
	output logic                               hold,
	output logic                               out_valid,
	output logic                               write_enable,
	output logic      [bats_pkg::TILE_W-1:0]   tile_value,
	output logic      [bats_pkg::COL_W-1:0]    column,
	output logic      [bats_pkg::ROW_W-1:0]    row
);
	import bats_pkg::*;

	slot_t                slot_s1;
	logic                 valid_s1;
	logic [CELL_BITS-1:0] left_q;

	logic                 valid_s2;
	logic                 we_s2;
	logic [TILE_W-1:0]    tile_s2;
	logic [COL_W-1:0]     col_s2;
	logic [ROW_W-1:0]     row_s2;

	logic [ENT_W-1:0]     lo_a;
	logic [ENT_W-1:0]     hi_a;
	logic [ENT_W-1:0]     lo_b;
	logic [ENT_W-1:0]     hi_b;
	logic [ENT_W-1:0]     top_ent;
	logic [ENT_W-1:0]     center_ent;
	logic [ENT_W-1:0]     right_ent;
	logic [CELL_BITS-1:0] center_val;
	logic [3:0]           mask;
	logic                 we;
	logic [TILE_W-1:0]    tile_sel;
	logic [TILE_W-1:0]    tile;
	logic                 s1_adv;

	assign s1_adv = !valid_s2 || !out_stall;
	assign hold   = valid_s1 && !s1_adv;

	// Pick the banks: the new row's bank holds the row above
	assign lo_a       = rdata_a[ENT_W-1:0];
	assign hi_a       = rdata_a[2*ENT_W-1:ENT_W];
	assign lo_b       = rdata_b[ENT_W-1:0];
	assign hi_b       = rdata_b[2*ENT_W-1:ENT_W];
	assign top_ent    = slot_s1.bank ? hi_a : lo_a;
	assign center_ent = slot_s1.bank ? lo_a : hi_a;
	assign right_ent  = slot_s1.bank ? lo_b : hi_b;
	assign center_val = center_ent[CELL_BITS-1:0];

	// Neighbor mask
	always_comb begin
		mask             = '0;
		mask[MASK_TOP]   = slot_s1.top_ok && (top_ent[CELL_BITS-1:0] != '0);
		mask[MASK_RIGHT] = slot_s1.right_ok && (right_ent[CELL_BITS-1:0] != '0);
		mask[MASK_BOT]   = slot_s1.bot_set;
		mask[MASK_LEFT]  = slot_s1.left_ok && (left_q != '0);
	end

	// Match test and tile lookup
	assign we       = !center_ent[ENT_W-1] && (32'(center_val) == 32'(match_value));
	assign tile_sel = tiles[mask[3:2]][mask[1:0]*TILE_W +: TILE_W];
	assign tile     = we ? tile_sel : '0;

	// Slot register, aligned with the registered line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load)
			valid_s1 <= 1'b1;
		else if (s1_adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			slot_s1 <= slot_in;
		if (valid_s1 && s1_adv)
			left_q <= center_val;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s1_adv)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_adv) begin
			we_s2   <= we;
			tile_s2 <= tile;
			col_s2  <= COL_W'(slot_s1.col);
			row_s2  <= slot_s1.row;
		end
	end

	assign out_valid    = valid_s2;
	assign write_enable = we_s2;
	assign tile_value   = tile_s2;
	assign column       = col_s2;
	assign row          = row_s2;

	// A held slot keeps its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> valid_s1 && $stable(slot_s1))
	else $error("held slot changed");

	// Never load over a slot that cannot move on
	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !hold)
	else $error("slot overwritten while held");

	// Unmatched cells carry a zero tile word
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !we_s2 |-> tile_s2 == '0)
	else $error("tile word set without write enable");

endmodule

`default_nettype wire

/* rtl/core/bitmask_autotile_stencil_core.sv */
// Four-neighbor bitmask autotile stencil. Cells stream in raster order, one word
// per clock while cell_stall is low; the result for a cell of row r is produced
// once the same column of row r+1 has gone in, so a padding row flushes the last
// row, and the first row of a grid gives no results. Two register stages sit
// between a cell and its result: the two-row line store (two registered reads and
// one write per clock) feeds a slot register, and the mask, match test and tile
// lookup feed the result register. So result_valid rises once the completing cell
// has passed the slot register and then the result register. A stalled result
// word holds the slot register, which holds cell_stall high. After reset the line
// store is cleared row by row, during which cell_stall stays high; register writes
// are taken as usual. Depends on bats_pkg and the bats_* modules.
`timescale 1ns / 1ps
`default_nettype none

module bitmask_autotile_stencil_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// APB configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bats_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [bats_pkg::PDATA_W-1:0]  pwdata,
	output logic      [bats_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	// cell channel
	input  wire logic                          cell_valid,
	output logic                               cell_stall,
	input  wire logic [bats_pkg::VAL_W-1:0]    cell_value,
	input  wire logic                          grid_start,
	input  wire logic                          padding,
	// result channel
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic                               write_enable,
	output logic      [bats_pkg::TILE_W-1:0]   tile_value,
	output logic      [bats_pkg::COL_W-1:0]    column,
	output logic      [bats_pkg::ROW_W-1:0]    row
);
	import bats_pkg::*;

	logic [GW_W-1:0]    grid_width;
	logic [MATCH_W-1:0] match_value;
	tile_bank_t         tiles;
	slot_t              slot;
	mem_wr_t            wr;
	mem_rd_t            rd;
	logic [2*ENT_W-1:0] rdata_a;
	logic [2*ENT_W-1:0] rdata_b;
	logic               mem_busy;
	logic               stage_hold;
	logic               fire;

	// Input handshake
	assign cell_stall = mem_busy || stage_hold;
	assign fire       = cell_valid && !cell_stall;

	bats_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.grid_width  (grid_width),
		.match_value (match_value),
		.tiles       (tiles)
	);

	bats_raster u_raster (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.cell_value (cell_value),
		.grid_start (grid_start),
		.padding    (padding),
		.grid_width (grid_width),
		.slot       (slot),
		.wr         (wr),
		.rd         (rd)
	);

	bats_line_mem u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ren     (fire),
		.rd      (rd),
		.wr      (wr),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b),
		.busy    (mem_busy)
	);

	bats_tile_stage u_tile_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire && slot.has_result),
		.slot_in      (slot),
		.rdata_a      (rdata_a),
		.rdata_b      (rdata_b),
		.match_value  (match_value),
		.tiles        (tiles),
		.out_stall    (result_stall),
		.hold         (stage_hold),
		.out_valid    (result_valid),
		.write_enable (write_enable),
		.tile_value   (tile_value),
		.column       (column),
		.row          (row)
	);

endmodule

`default_nettype wire

/* bench/tile_checker.sv */
// Checker for the autotile stencil core: watches the APB port and both word channels,
// predicts each tile result from its own line store model and compares field by field.
// Depends on bats_pkg for widths, mask bit positions and register indexes.
`timescale 1ns / 1ps

module tile_checker
	import bats_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	input  logic                cell_valid,
	input  logic                cell_stall,
	input  logic [VAL_W-1:0]    cell_value,
	input  logic                grid_start,
	input  logic                padding,
	input  logic                result_valid,
	input  logic                result_stall,
	input  logic                write_enable,
	input  logic [TILE_W-1:0]   tile_value,
	input  logic [COL_W-1:0]    column,
	input  logic [ROW_W-1:0]    row,
	output int                  tiles_pending,
	output int                  mismatches
);

	typedef struct packed {
		logic              we;
		logic [TILE_W-1:0] tile;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} tile_result_t;

	// configuration copy
	logic [GW_W-1:0]    grid_w;
	logic [MATCH_W-1:0] match_val;
	logic [63:0]        tile_regs [4];

	// two-row line store model: values and padding flags, one half per bank
	logic [VAL_W-1:0] line_val [2*MAX_WIDTH];
	logic             line_pad [2*MAX_WIDTH];
	int               col_cnt;
	logic [ROW_W-1:0] row_cnt;
	logic [VAL_W-1:0] left_val;
	logic             first_row;
	logic             bank;

	tile_result_t tiles_due [$];
	int           err_cnt = 0;

	task automatic advance_row();
		if (first_row)
			first_row = 1'b0;
		else if (row_cnt < ROW_MAX)
			row_cnt++;
		bank     = ~bank;
		col_cnt  = 0;
		left_val = '0;
	endtask

	// one cell in: update the line store, queue the tile for the cell one row up
	task automatic predict_tile(input logic [VAL_W-1:0] value, input logic gs,
		input logic pad);
		int               w;
		int               c;
		int               ib;
		int               cb;
		logic [VAL_W-1:0] v;
		logic [VAL_W-1:0] center;
		logic [3:0]       mask;
		tile_result_t     r;
		if (grid_w == '0)
			w = 1;
		else if (int'(grid_w) > MAX_WIDTH)
			w = MAX_WIDTH;
		else
			w = int'(grid_w);
		v = pad ? '0 : value;

		if (gs) begin
			first_row = 1'b1;
			row_cnt   = '0;
			bank      = 1'b0;
			col_cnt   = 0;
			left_val  = '0;
		end else if (col_cnt >= w) begin
			advance_row();
		end

		c  = col_cnt;
		ib = bank ? MAX_WIDTH : 0;
		cb = bank ? 0 : MAX_WIDTH;

		if (!first_row) begin
			center           = line_val[cb+c];
			mask             = '0;
			mask[MASK_TOP]   = row_cnt > 0 && line_val[ib+c] != '0;
			mask[MASK_RIGHT] = c + 1 < w && line_val[cb+c+1] != '0;
			mask[MASK_BOT]   = v != '0;
			mask[MASK_LEFT]  = c > 0 && left_val != '0;
			r.we   = !line_pad[cb+c] && center == match_val;
			r.tile = r.we ? tile_regs[mask[3:2]][16*mask[1:0] +: 16] : '0;
			r.col  = c[COL_W-1:0];
			r.row  = row_cnt;
			tiles_due.push_back(r);
			left_val = center;
		end

		line_val[ib+c] = v;
		line_pad[ib+c] = pad;

		if (c + 1 >= w)
			advance_row();
		else
			col_cnt = c + 1;
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			err_cnt++;
		end
	endtask

	task automatic check_result();
		tile_result_t e;
		if (tiles_due.size() == 0) begin
			$error("result word with no tile expected: column %0d row %0d",
				column, row);
			err_cnt++;
		end else begin
			e = tiles_due.pop_front();
			check_field("write_enable", e.we, write_enable);
			check_field("tile_value", e.tile, tile_value);
			check_field("column", e.col, column);
			check_field("row", e.row, row);
		end
	endtask

	task automatic apply_config();
		case (reg_idx_t'(paddr[5:3]))
			REG_GRID_WIDTH:  grid_w       = pwdata[GW_W-1:0];
			REG_MATCH_VALUE: match_val    = pwdata[MATCH_W-1:0];
			REG_TILES_0_3:   tile_regs[0] = pwdata;
			REG_TILES_4_7:   tile_regs[1] = pwdata;
			REG_TILES_8_11:  tile_regs[2] = pwdata;
			REG_TILES_12_15: tile_regs[3] = pwdata;
			default: ;
		endcase
	endtask

	// results are checked before the same edge's cell is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w    = GW_W'(1);
			match_val = MATCH_W'(1);
			for (int i = 0; i < 4; i++)
				tile_regs[i] = '0;
			for (int i = 0; i < 2*MAX_WIDTH; i++) begin
				line_val[i] = '0;
				line_pad[i] = 1'b0;
			end
			col_cnt   = 0;
			row_cnt   = '0;
			left_val  = '0;
			first_row = 1'b1;
			bank      = 1'b0;
			tiles_due.delete();
		end else begin
			if (psel && penable && pwrite && pready)
				apply_config();
			if (result_valid && !result_stall)
				check_result();
			if (cell_valid && !cell_stall)
				predict_tile(cell_value, grid_start, padding);
		end
		tiles_pending <= tiles_due.size();
		mismatches    <= err_cnt;
	end

endmodule

/* bench/tb_top.sv */
// Top of the autotile stencil bench: clock, reset, APB writes, cell stimulus and
// result stall bursts; tile_checker does the prediction. Depends on bats_pkg,
// tile_checker and bitmask_autotile_stencil_core.
`timescale 1ns / 1ps

module tb_top;
	import bats_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [PDATA_W-1:0] pwdata       = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               cell_valid   = 1'b0;
	logic               cell_stall;
	logic [VAL_W-1:0]   cell_value   = '0;
	logic               grid_start   = 1'b0;
	logic               padding      = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic               write_enable;
	logic [TILE_W-1:0]  tile_value;
	logic [COL_W-1:0]   column;
	logic [ROW_W-1:0]   row;

	int                 tiles_pending;
	int                 mismatches;
	logic               idle_en      = 1'b1;
	logic [VAL_W-1:0]   cur_match    = VAL_W'(1);
	int unsigned        items_sent   = 0;
	int unsigned        quiet_cycles = 0;
	int unsigned        stall_left   = 0;

	bitmask_autotile_stencil_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.cell_valid   (cell_valid),
		.cell_stall   (cell_stall),
		.cell_value   (cell_value),
		.grid_start   (grid_start),
		.padding      (padding),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.write_enable (write_enable),
		.tile_value   (tile_value),
		.column       (column),
		.row          (row)
	);

	tile_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.cell_valid    (cell_valid),
		.cell_stall    (cell_stall),
		.cell_value    (cell_value),
		.grid_start    (grid_start),
		.padding       (padding),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.write_enable  (write_enable),
		.tile_value    (tile_value),
		.column        (column),
		.row           (row),
		.tiles_pending (tiles_pending),
		.mismatches    (mismatches)
	);

	always #5 clk = ~clk;

	// random result side stall bursts, enabled by idle_en
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left   <= 0;
		end else if (!idle_en) begin
			result_stall <= 1'b0;
			stall_left   <= 0;
		end else if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left   <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			result_stall <= 1'b1;
			stall_left   <= $urandom_range(0, 5);
		end else begin
			result_stall <= 1'b0;
		end
	end

	// watchdog: too long without any word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (cell_valid && !cell_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// mix of matching, zero, all-ones and random cells
	function automatic logic [VAL_W-1:0] pick_cell();
		logic [VAL_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = cur_match;
			3, 4, 5: v = '0;
			6:       v = '1;
			default: v = VAL_W'($urandom);
		endcase
		return v;
	endfunction

	task automatic send_cell(input logic [VAL_W-1:0] value, input logic gs,
		input logic pad);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			cell_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		cell_valid <= 1'b1;
		cell_value <= value;
		grid_start <= gs;
		padding    <= pad;
		@(posedge clk);
		while (cell_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_pad_row(input int w);
		for (int i = 0; i < w; i++)
			send_cell(VAL_W'($urandom), 1'b0, 1'b1);
	endtask

	// well-formed grid: h rows of w cells and one or two flush rows
	task automatic send_grid(input int w, input int h);
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++)
				send_cell(pick_cell(), r == 0 && c == 0, 1'b0);
		repeat ($urandom_range(1, 2)) send_pad_row(w);
	endtask

	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++)
			send_cell(pick_cell(), $urandom_range(0, 19) == 0, $urandom_range(0, 3) == 0);
	endtask

	// hold off the sender until every expected tile is back and the pipe is empty
	task automatic drain();
		cell_valid <= 1'b0;
		@(posedge clk);
		while (tiles_pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [63:0] pattern;
		int unsigned rnd_start;
		int          phase_no;
		int unsigned gw;
		int          eff;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// distinct tile word per mask so a wrong mask shows up
		for (int k = 0; k < 4; k++) begin
			for (int j = 0; j < 4; j++)
				pattern[16*j +: 16] = 16'(16'h1111 * (4*k + j)) ^ 16'h5A00;
			apb_write(reg_idx_t'(int'(REG_TILES_0_3) + k), pattern);
		end
		apb_write(REG_GRID_WIDTH, 64'd3);
		apb_write(REG_MATCH_VALUE, 64'd1);
		cur_match = VAL_W'(1);

		// stream begins without a grid start, 3x3 grid then a flush row
		send_cell(16'h0001, 1'b0, 1'b0);
		send_cell(16'h0001, 1'b0, 1'b0);
		send_cell(16'h0000, 1'b0, 1'b0);
		send_cell(16'h0001, 1'b0, 1'b0);
		send_cell(16'h0000, 1'b0, 1'b0);
		send_cell(16'h0001, 1'b0, 1'b0);
		send_cell(16'h0000, 1'b0, 1'b0);
		send_cell(16'h0001, 1'b0, 1'b0);
		send_cell(16'hFFFF, 1'b0, 1'b0);
		send_pad_row(3);

		// match on zero: grid restarted mid-grid, then padding rows must not write
		drain();
		apb_write(REG_GRID_WIDTH, 64'd2);
		apb_write(REG_MATCH_VALUE, 64'd0);
		cur_match = '0;
		send_cell(16'h0007, 1'b1, 1'b0);
		send_cell(16'h0007, 1'b0, 1'b0);
		send_cell(16'h0003, 1'b0, 1'b0);
		send_cell(16'h0000, 1'b1, 1'b0);
		send_cell(16'h0000, 1'b0, 1'b0);
		send_cell(16'h0000, 1'b0, 1'b0);
		send_cell(16'hFFFF, 1'b0, 1'b0);
		send_cell(16'hFFFF, 1'b0, 1'b1);
		send_cell(16'hFFFF, 1'b0, 1'b1);
		send_pad_row(2);

		// random phases; width zero and the widest row come first
		rnd_start = items_sent;
		phase_no  = 0;
		while (items_sent - rnd_start < 1050) begin
			drain();
			if (items_sent - rnd_start >= 900)
				idle_en <= 1'b0;
			else
				idle_en <= ($urandom_range(0, 3) != 0);

			case (phase_no)
				0:       gw = 0;
				1:       gw = $urandom_range(0, 1) ? 256 : 511;
				default: begin
					case ($urandom_range(0, 9))
						7, 8:    gw = $urandom_range(9, 40);
						default: gw = $urandom_range(1, 8);
					endcase
				end
			endcase
			apb_write(REG_GRID_WIDTH, 64'(gw));
			if (gw == 0)
				eff = 1;
			else if (gw > MAX_WIDTH)
				eff = MAX_WIDTH;
			else
				eff = int'(gw);

			if (phase_no < 2 || $urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 5))
					0:       cur_match = '0;
					1:       cur_match = '1;
					2, 3:    cur_match = VAL_W'($urandom_range(1, 3));
					default: cur_match = VAL_W'($urandom);
				endcase
				apb_write(REG_MATCH_VALUE, 64'(cur_match));
			end
			for (int k = 0; k < 4; k++)
				if ($urandom_range(0, 2) == 0)
					apb_write(reg_idx_t'(int'(REG_TILES_0_3) + k), {$urandom, $urandom});

			if (phase_no >= 2 && $urandom_range(0, 4) == 0)
				send_noise($urandom_range(10, 40));
			else
				send_grid(eff, eff > 64 ? 1 : $urandom_range(1, 6));
			phase_no++;
		end

		drain();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
